@@ hw/rtl/fus_pkg.sv @@
// Package: shared types, codes and helper functions of the firmware upgrade sequencer.
`timescale 1ns / 1ps

package fus_pkg;

	localparam int unsigned SIZE_W   = 24;
	localparam int unsigned RETRY_W  = 8;
	localparam int unsigned CODE_W   = 8;
	localparam int unsigned LEN_W    = 8;
	localparam int unsigned PKT_W    = 18;
	localparam int unsigned PROG_W   = 7;
	localparam int unsigned QUOT_W   = 7;
	localparam int unsigned ADDR_W   = 5;
	localparam int unsigned DATA_W   = 32;

	localparam logic [LEN_W-1:0] CHUNK_BYTES = 8'd128;
	localparam logic [RETRY_W-1:0] RETRY_SAT = 8'd255;

	// Event kinds.
	localparam logic [2:0] KIND_START   = 3'd0;
	localparam logic [2:0] KIND_REPLY   = 3'd1;
	localparam logic [2:0] KIND_TIMEOUT = 3'd2;
	localparam logic [2:0] KIND_CANCEL  = 3'd3;
	localparam logic [2:0] KIND_WAIT    = 3'd4;

	// Commands.
	localparam logic [2:0] CMD_NONE    = 3'd0;
	localparam logic [2:0] CMD_REQUEST = 3'd1;
	localparam logic [2:0] CMD_ERASE   = 3'd2;
	localparam logic [2:0] CMD_DATA    = 3'd3;
	localparam logic [2:0] CMD_JUMP    = 3'd4;
	localparam logic [2:0] CMD_WAIT    = 3'd5;

	// Phases.
	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_REQ    = 3'd1;
	localparam logic [2:0] PH_ERASE  = 3'd2;
	localparam logic [2:0] PH_XFER   = 3'd3;
	localparam logic [2:0] PH_FINISH = 3'd4;
	localparam logic [2:0] PH_DONE   = 3'd5;
	localparam logic [2:0] PH_FAIL   = 3'd6;

	// Packet outcomes.
	localparam logic [1:0] OUT_NONE      = 2'd0;
	localparam logic [1:0] OUT_OK        = 2'd1;
	localparam logic [1:0] OUT_FAILRETRY = 2'd2;
	localparam logic [1:0] OUT_TIMERETRY = 2'd3;

	// Progress marks.
	localparam logic [PROG_W-1:0] PROG_ZERO   = 7'd0;
	localparam logic [PROG_W-1:0] PROG_ERASE  = 7'd5;
	localparam logic [PROG_W-1:0] PROG_XFER   = 7'd10;
	localparam logic [PROG_W-1:0] PROG_FINISH = 7'd95;
	localparam logic [PROG_W-1:0] PROG_DONE   = 7'd100;

	// Register indexes.
	localparam logic [2:0] REG_IMAGE_SIZE  = 3'd0;
	localparam logic [2:0] REG_MAX_RETRIES = 3'd1;
	localparam logic [2:0] REG_BOOT_READY  = 3'd2;
	localparam logic [2:0] REG_BOOT_STATUS = 3'd3;
	localparam logic [2:0] REG_APP_JUMPING = 3'd4;
	localparam logic [2:0] REG_SUCCESS     = 3'd5;

	typedef struct packed {
		logic [SIZE_W-1:0]  image_size;
		logic [RETRY_W-1:0] max_retries;
		logic [CODE_W-1:0]  boot_ready_code;
		logic [CODE_W-1:0]  boot_status_code;
		logic [CODE_W-1:0]  app_jumping_code;
		logic [CODE_W-1:0]  success_code;
	} cfg_t;

	typedef struct packed {
		logic [2:0]        command;
		logic [SIZE_W-1:0] chunk_offset;
		logic [LEN_W-1:0]  chunk_length;
		logic [2:0]        phase;
		logic [PROG_W-1:0] progress;
		logic [PKT_W-1:0]  packet_number;
		logic [1:0]        packet_outcome;
		logic              finished;
		logic              succeeded;
	} result_t;

	typedef struct packed {
		logic              start;
		logic [SIZE_W-1:0] offset;
		logic [SIZE_W-1:0] size;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] quot;
	} div_rsp_t;

	// Length of the next chunk: what is left of the image, at most one chunk.
	function automatic logic [LEN_W-1:0] chunk_len(input logic [SIZE_W-1:0] size,
			input logic [SIZE_W-1:0] off);
		logic [SIZE_W-1:0] remaining;
		remaining = (size > off) ? (size - off) : '0;
		if (remaining < SIZE_W'(CHUNK_BYTES)) begin
			return remaining[LEN_W-1:0];
		end
		return CHUNK_BYTES;
	endfunction

endpackage

@@ hw/rtl/fus_intf.sv @@
// Interfaces: event channel into and result channel out of the sequencer.
`timescale 1ns / 1ps

interface fus_evt_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic       has_status;
	logic [7:0] status_byte;

	modport source(output valid, output kind, output has_status, output status_byte,
		input ready);
	modport sink(input valid, input kind, input has_status, input status_byte,
		output ready);
endinterface

interface fus_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic [23:0] chunk_offset;
	logic [7:0]  chunk_length;
	logic [2:0]  phase;
	logic [6:0]  progress;
	logic [17:0] packet_number;
	logic [1:0]  packet_outcome;
	logic        finished;
	logic        succeeded;

	modport source(output valid, output command, output chunk_offset, output chunk_length,
		output phase, output progress, output packet_number, output packet_outcome,
		output finished, output succeeded, input ready);
	modport sink(input valid, input command, input chunk_offset, input chunk_length,
		input phase, input progress, input packet_number, input packet_outcome,
		input finished, input succeeded, output ready);
endinterface

@@ hw/rtl/fus_cfg.sv @@
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps

module fus_cfg import fus_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic [2:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[ADDR_W-1:2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_size       <= '0;
			cfg_q.max_retries      <= 8'd3;
			cfg_q.boot_ready_code  <= 8'd0;
			cfg_q.boot_status_code <= 8'd1;
			cfg_q.app_jumping_code <= 8'd2;
			cfg_q.success_code     <= 8'd0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_IMAGE_SIZE:  cfg_q.image_size       <= pwdata[SIZE_W-1:0];
				REG_MAX_RETRIES: cfg_q.max_retries      <= pwdata[RETRY_W-1:0];
				REG_BOOT_READY:  cfg_q.boot_ready_code  <= pwdata[CODE_W-1:0];
				REG_BOOT_STATUS: cfg_q.boot_status_code <= pwdata[CODE_W-1:0];
				REG_APP_JUMPING: cfg_q.app_jumping_code <= pwdata[CODE_W-1:0];
				REG_SUCCESS:     cfg_q.success_code     <= pwdata[CODE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_IMAGE_SIZE:  prdata = DATA_W'(cfg_q.image_size);
			REG_MAX_RETRIES: prdata = DATA_W'(cfg_q.max_retries);
			REG_BOOT_READY:  prdata = DATA_W'(cfg_q.boot_ready_code);
			REG_BOOT_STATUS: prdata = DATA_W'(cfg_q.boot_status_code);
			REG_APP_JUMPING: prdata = DATA_W'(cfg_q.app_jumping_code);
			REG_SUCCESS:     prdata = DATA_W'(cfg_q.success_code);
			default:         prdata = '0;
		endcase
	end

endmodule

@@ hw/rtl/fus_div.sv @@
// Iterative progress divider: floor(85 * offset / size), one quotient bit per cycle.
`timescale 1ns / 1ps

module fus_div import fus_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int unsigned REM_W = SIZE_W + 7;
	localparam int unsigned DSH_W = SIZE_W + QUOT_W - 1;

	logic              busy_q;
	logic              mul_q;
	logic              done_q;
	logic [2:0]        cnt_q;
	logic [SIZE_W-1:0] off_q;
	logic [REM_W-1:0]  rem_q;
	logic [DSH_W-1:0]  dsh_q;
	logic [QUOT_W-1:0] quot_q;
	logic [REM_W-1:0]  mul85;
	logic              ge;

	// 85 = 64 + 16 + 4 + 1, done with shifts and adds.
	assign mul85 = (REM_W'(off_q) << 6) + (REM_W'(off_q) << 4) + (REM_W'(off_q) << 2)
		+ REM_W'(off_q);
	assign ge = rem_q >= REM_W'(dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			mul_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// The quotient is complete after the last step.
			done_q <= !req.start && !mul_q && busy_q && (cnt_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
				mul_q  <= 1'b1;
			end else if (mul_q) begin
				mul_q <= 1'b0;
				cnt_q <= 3'(QUOT_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 3'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			off_q <= req.offset;
			dsh_q <= {req.size, (QUOT_W-1)'(0)};
		end else if (mul_q) begin
			rem_q  <= mul85;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? (rem_q - REM_W'(dsh_q)) : rem_q;
			dsh_q  <= dsh_q >> 1;
			quot_q <= {quot_q[QUOT_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

@@ hw/rtl/firmware_upgrade_sequencer.sv @@
// Top level: firmware upgrade sequencer with event and result channels and config port.
// An accepted event is registered, executed, and its result moved to the output
// register once that is free; an event that advances a data transfer without ending
// it first waits for the divider (a multiply step and seven quotient steps) that
// computes the progress percent. Events are handled one at a time.
// Reset (arst_n, asynchronous, active low) clears the sequencer to idle and the
// configuration registers to their defaults; no clearing pass is needed.
`timescale 1ns / 1ps

module firmware_upgrade_sequencer import fus_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	fus_evt_if.sink           evt,
	fus_res_if.source         res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	// Sequencer control states.
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	cfg_t     cfg;
	div_req_t div_req;
	div_rsp_t div_rsp;

	logic [1:0] state_q;

	// The event word being worked on.
	logic [2:0]        kind_q;
	logic              has_q;
	logic [CODE_W-1:0] status_q;

	// Upgrade state.
	logic [2:0]         phase_q;
	logic [RETRY_W-1:0] retry_q;
	logic [SIZE_W-1:0]  offset_q;
	logic [PKT_W-1:0]   pkt_q;
	logic [LEN_W-1:0]   chunk_q;
	logic               cancel_q;
	logic [PROG_W-1:0]  prog_q;

	// Pending result and the output register.
	result_t pend_q;
	result_t out_q;
	logic    out_valid_q;

	// Next-state values computed in the execute cycle.
	logic [2:0]         n_phase;
	logic [RETRY_W-1:0] n_retry;
	logic [SIZE_W-1:0]  n_offset;
	logic [PKT_W-1:0]   n_pkt;
	logic [LEN_W-1:0]   n_chunk;
	logic               n_cancel;
	logic [PROG_W-1:0]  n_prog;
	logic               need_div;
	result_t            r;

	logic [RETRY_W-1:0] bumped;
	logic               bump_fail;
	logic [SIZE_W:0]    sum;
	logic               status_ok;
	logic               load_out;

	fus_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fus_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// The retry counter saturates; the phase fails once it reaches max_retries.
	assign bumped    = (retry_q == RETRY_SAT) ? RETRY_SAT : (retry_q + 8'd1);
	assign bump_fail = bumped >= cfg.max_retries;
	// The end-of-image test uses the unmasked sum.
	assign sum       = {1'b0, offset_q} + (SIZE_W+1)'(chunk_q);
	assign status_ok = has_q && (status_q == cfg.success_code);

	// Execute cycle: all the decisions for one event, except the progress division.
	always_comb begin
		n_phase  = phase_q;
		n_retry  = retry_q;
		n_offset = offset_q;
		n_pkt    = pkt_q;
		n_chunk  = chunk_q;
		n_cancel = cancel_q;
		n_prog   = prog_q;
		need_div = 1'b0;
		r        = '0;

		case (kind_q)
			KIND_START: begin
				n_offset  = '0;
				n_pkt     = '0;
				n_retry   = '0;
				n_chunk   = '0;
				n_cancel  = 1'b0;
				n_phase   = PH_REQ;
				n_prog    = PROG_ZERO;
				r.command = CMD_REQUEST;
			end
			KIND_REPLY, KIND_TIMEOUT: begin
				case (phase_q)
					PH_REQ: begin
						if (kind_q == KIND_REPLY && has_q &&
								(status_q == cfg.boot_ready_code ||
								status_q == cfg.boot_status_code)) begin
							n_phase   = PH_ERASE;
							n_prog    = PROG_ERASE;
							r.command = CMD_ERASE;
						end else if (kind_q == KIND_REPLY && has_q &&
								status_q == cfg.app_jumping_code) begin
							r.command = CMD_WAIT;
						end else begin
							n_retry = bumped;
							if (bump_fail) begin
								n_phase    = PH_FAIL;
								n_prog     = PROG_ZERO;
								r.finished = 1'b1;
							end else begin
								r.command = CMD_REQUEST;
							end
						end
					end
					PH_ERASE: begin
						if (kind_q == KIND_REPLY && status_ok) begin
							n_phase        = PH_XFER;
							n_retry        = '0;
							n_prog         = PROG_XFER;
							n_chunk        = chunk_len(cfg.image_size, offset_q);
							r.command      = CMD_DATA;
							r.chunk_offset = offset_q;
							r.chunk_length = n_chunk;
						end else begin
							n_phase    = PH_FAIL;
							n_prog     = PROG_ZERO;
							r.finished = 1'b1;
						end
					end
					PH_XFER: begin
						r.packet_number = pkt_q;
						if (kind_q == KIND_REPLY && status_ok) begin
							r.packet_outcome = OUT_OK;
							n_retry          = '0;
							n_offset         = sum[SIZE_W-1:0];
							n_pkt            = pkt_q + 18'd1;
							if (sum >= {1'b0, cfg.image_size}) begin
								n_phase   = PH_FINISH;
								n_prog    = PROG_FINISH;
								r.command = CMD_JUMP;
							end else begin
								// Progress comes from the divider afterwards.
								need_div       = 1'b1;
								n_chunk        = chunk_len(cfg.image_size, n_offset);
								r.command      = CMD_DATA;
								r.chunk_offset = n_offset;
								r.chunk_length = n_chunk;
							end
						end else begin
							r.packet_outcome = (kind_q == KIND_REPLY) ? OUT_FAILRETRY
								: OUT_TIMERETRY;
							n_retry = bumped;
							if (bump_fail) begin
								n_phase    = PH_FAIL;
								n_prog     = PROG_ZERO;
								r.finished = 1'b1;
							end else begin
								n_chunk        = chunk_len(cfg.image_size, offset_q);
								r.command      = CMD_DATA;
								r.chunk_offset = offset_q;
								r.chunk_length = n_chunk;
							end
						end
					end
					PH_FINISH: begin
						r.finished = 1'b1;
						if (kind_q == KIND_REPLY && status_ok) begin
							n_phase     = PH_DONE;
							n_prog      = PROG_DONE;
							r.succeeded = 1'b1;
						end else begin
							n_phase = PH_FAIL;
							n_prog  = PROG_ZERO;
						end
					end
					default: ;
				endcase
			end
			KIND_CANCEL: begin
				if (!(phase_q inside {PH_IDLE, PH_DONE, PH_FAIL})) begin
					n_cancel   = 1'b1;
					n_phase    = PH_FAIL;
					n_prog     = PROG_ZERO;
					r.finished = 1'b1;
				end
			end
			KIND_WAIT: begin
				// The re-request is sent only while still requesting and not cancelled.
				if (!cancel_q && phase_q == PH_REQ) begin
					r.command = CMD_REQUEST;
				end
			end
			default: ;
		endcase

		r.phase    = n_phase;
		r.progress = n_prog;
	end

	assign div_req.start  = (state_q == S_EXEC) && need_div;
	assign div_req.offset = n_offset;
	assign div_req.size   = cfg.image_size;

	// The pending result moves to the output register once that register is free.
	assign load_out = (state_q == S_OUT) && (!out_valid_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			phase_q     <= PH_IDLE;
			retry_q     <= '0;
			offset_q    <= '0;
			pkt_q       <= '0;
			chunk_q     <= '0;
			cancel_q    <= 1'b0;
			prog_q      <= '0;
		end else begin
			// A new word replaces the one being taken in the same cycle.
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (evt.valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					phase_q  <= n_phase;
					retry_q  <= n_retry;
					offset_q <= n_offset;
					pkt_q    <= n_pkt;
					chunk_q  <= n_chunk;
					cancel_q <= n_cancel;
					prog_q   <= n_prog;
					state_q  <= need_div ? S_DIV : S_OUT;
				end
				S_DIV: begin
					if (div_rsp.done) begin
						prog_q  <= PROG_XFER + div_rsp.quot;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && evt.valid) begin
			kind_q   <= evt.kind;
			has_q    <= evt.has_status;
			status_q <= evt.status_byte;
		end
		if (state_q == S_EXEC) begin
			pend_q <= r;
		end else if (state_q == S_DIV && div_rsp.done) begin
			pend_q.progress <= PROG_XFER + div_rsp.quot;
		end
		if (load_out) begin
			out_q <= pend_q;
		end
	end

	// An event word is taken only while the sequencer waits for one.
	assign evt.ready = (state_q == S_IDLE);

	assign res.valid          = out_valid_q;
	assign res.command        = out_q.command;
	assign res.chunk_offset   = out_q.chunk_offset;
	assign res.chunk_length   = out_q.chunk_length;
	assign res.phase          = out_q.phase;
	assign res.progress       = out_q.progress;
	assign res.packet_number  = out_q.packet_number;
	assign res.packet_outcome = out_q.packet_outcome;
	assign res.finished       = out_q.finished;
	assign res.succeeded      = out_q.succeeded;

endmodule

@@ hw/rtl/fus_checker.sv @@
// Checker on the top-level ports of the sequencer, with its bind statement.
`timescale 1ns / 1ps

module fus_checker import fus_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       evt_valid,
	input logic       evt_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic [2:0] res_command,
	input logic [2:0] res_phase,
	input logic [6:0] res_progress,
	input logic       res_finished,
	input logic       res_succeeded
);

	// A result word that is not taken stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result word dropped while stalled");

	// The sequencer is busy in the cycle after it takes an event word.
	assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_ready |=> !evt_ready)
		else $error("event word taken while busy");

	// A finished upgrade sends no command.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_finished |-> res_command == CMD_NONE)
		else $error("command sent on the finishing word");

	// Success is reported only when finished, completed, at full progress.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_succeeded |->
			res_finished && res_phase == PH_DONE && res_progress == PROG_DONE)
		else $error("success reported inconsistently");

	// Data chunks are sent only while transferring.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_command == CMD_DATA |-> res_phase == PH_XFER)
		else $error("data chunk outside the transfer phase");

endmodule

bind firmware_upgrade_sequencer fus_checker u_fus_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.evt_valid     (evt.valid),
	.evt_ready     (evt.ready),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.res_command   (res.command),
	.res_phase     (res.phase),
	.res_progress  (res.progress),
	.res_finished  (res.finished),
	.res_succeeded (res.succeeded)
);

@@ verif/tb_top.sv @@
// Self-checking testbench for the firmware upgrade sequencer: event stream in, result words out.
`timescale 1ns / 1ps

module tb_top;
	import fus_pkg::*;

	// The run is cut off here. A correct run needs far fewer cycles, even
	// with the slowest idling mode and the long receiver hold-off.
	localparam int unsigned CYCLE_LIMIT = 1000000;
	// Length of the receiver hold-off that makes the block back up.
	localparam int unsigned HOLD_CYCLES = 300;

	typedef struct packed {
		logic [2:0] kind;
		logic       has_status;
		logic [7:0] status_byte;
	} seq_event_t;

	// Clock and reset.
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	initial begin
		forever #2 clk = ~clk;
	end

	// Configuration port. Only the stimulus process drives these.
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	// Event and result channels. The testbench drives its side of each channel
	// from local variables, so that every input has a known value from time 0.
	fus_evt_if evt_ch();
	fus_res_if res_ch();

	logic       ev_valid = 1'b0;
	logic [2:0] ev_kind = KIND_START;
	logic       ev_has = 1'b0;
	logic [7:0] ev_status = '0;
	logic       take_ready = 1'b0;

	assign evt_ch.valid = ev_valid;
	assign evt_ch.kind = ev_kind;
	assign evt_ch.has_status = ev_has;
	assign evt_ch.status_byte = ev_status;
	assign res_ch.ready = take_ready;

	firmware_upgrade_sequencer dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.evt     (evt_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Events waiting to be offered, and result words waiting to arrive.
	seq_event_t  pending_events[$];
	result_t     expected_words[$];
	int unsigned events_queued = 0;
	int unsigned events_taken = 0;
	int unsigned words_seen = 0;
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;

	// Idling knobs, in percent of cycles. Changed only at rising edges.
	int unsigned send_gap_pct = 9;
	int unsigned recv_gap_pct = 80;

	// A toggle of hold_req asks the receiver process for one long hold-off.
	bit          hold_req = 1'b0;
	bit          hold_ack = 1'b0;
	int unsigned hold_left = 0;

	// Set at each rising edge when the offered event was taken.
	logic event_accepted = 1'b0;

	// Shadow of the configuration registers, starting from their reset values.
	cfg_t cfg_now = '{image_size: '0, max_retries: 8'd3, boot_ready_code: 8'd0,
		boot_status_code: 8'd1, app_jumping_code: 8'd2, success_code: 8'd0};

	// Shadow of the sequencer state, advanced once per accepted event.
	logic [2:0]         seq_phase = PH_IDLE;
	logic [RETRY_W-1:0] retry_cnt = '0;
	logic [SIZE_W-1:0]  sent_off = '0;
	logic [PKT_W-1:0]   pkt_idx = '0;
	logic [LEN_W-1:0]   chunk_bytes = '0;
	bit                 was_cancelled = 1'b0;
	logic [PROG_W-1:0]  pct = PROG_ZERO;
	result_t            out_word;

	function automatic bit chance(input int unsigned pct_in);
		return $urandom_range(99, 0) < pct_in;
	endfunction

	function automatic string show(input result_t w);
		return $sformatf("cmd=%0d off=%0d len=%0d phase=%0d pct=%0d pkt=%0d outcome=%0d fin=%0d ok=%0d",
			w.command, w.chunk_offset, w.chunk_length, w.phase, w.progress,
			w.packet_number, w.packet_outcome, w.finished, w.succeeded);
	endfunction

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Ends the upgrade. A failure drops the progress back to zero.
	function automatic void end_run(input bit ok);
		seq_phase = ok ? PH_DONE : PH_FAIL;
		pct = ok ? PROG_DONE : PROG_ZERO;
		out_word.command = CMD_NONE;
		out_word.finished = 1'b1;
		out_word.succeeded = ok;
	endfunction

	// Counts one retry, saturating, and tells whether the limit is reached.
	function automatic bit count_retry();
		if (retry_cnt != RETRY_SAT) begin
			retry_cnt = retry_cnt + 1'b1;
		end
		return retry_cnt >= cfg_now.max_retries;
	endfunction

	// Sends the chunk at the current offset. When the image has shrunk below
	// the offset, nothing is left and the chunk is empty.
	function automatic void issue_chunk();
		int unsigned left;
		left = (cfg_now.image_size > sent_off) ? cfg_now.image_size - sent_off : 0;
		chunk_bytes = (left < CHUNK_BYTES) ? LEN_W'(left) : CHUNK_BYTES;
		out_word.command = CMD_DATA;
		out_word.chunk_offset = sent_off;
		out_word.chunk_length = chunk_bytes;
	endfunction

	function automatic void resend_request();
		if (count_retry()) begin
			end_run(1'b0);
		end else begin
			out_word.command = CMD_REQUEST;
		end
	endfunction

	function automatic void resend_chunk(input logic [1:0] outcome);
		out_word.packet_number = pkt_idx;
		out_word.packet_outcome = outcome;
		if (count_retry()) begin
			end_run(1'b0);
		end else begin
			issue_chunk();
		end
	endfunction

	// Works out the result word of one event and advances the shadow state.
	function automatic result_t predict_event(input seq_event_t e);
		int unsigned total;
		int unsigned q;
		bit          ok;
		out_word = '0;
		ok = e.has_status && (e.status_byte == cfg_now.success_code);
		case (e.kind)
			KIND_START: begin
				sent_off = '0;
				pkt_idx = '0;
				retry_cnt = '0;
				chunk_bytes = '0;
				was_cancelled = 1'b0;
				seq_phase = PH_REQ;
				pct = PROG_ZERO;
				out_word.command = CMD_REQUEST;
			end
			KIND_REPLY: begin
				case (seq_phase)
					PH_REQ: begin
						// Boot codes win over the jumping code when they overlap.
						if (!e.has_status) begin
							resend_request();
						end else if (e.status_byte == cfg_now.boot_ready_code ||
								e.status_byte == cfg_now.boot_status_code) begin
							seq_phase = PH_ERASE;
							pct = PROG_ERASE;
							out_word.command = CMD_ERASE;
						end else if (e.status_byte == cfg_now.app_jumping_code) begin
							out_word.command = CMD_WAIT;
						end else begin
							resend_request();
						end
					end
					PH_ERASE: begin
						if (ok) begin
							seq_phase = PH_XFER;
							retry_cnt = '0;
							pct = PROG_XFER;
							issue_chunk();
						end else begin
							end_run(1'b0);
						end
					end
					PH_XFER: begin
						if (ok) begin
							// The end test uses the unmasked sum.
							total = int'(sent_off) + int'(chunk_bytes);
							retry_cnt = '0;
							out_word.packet_number = pkt_idx;
							out_word.packet_outcome = OUT_OK;
							sent_off = SIZE_W'(total);
							pkt_idx = pkt_idx + 1'b1;
							if (total >= int'(cfg_now.image_size)) begin
								seq_phase = PH_FINISH;
								pct = PROG_FINISH;
								out_word.command = CMD_JUMP;
							end else begin
								q = (85 * int'(sent_off)) / int'(cfg_now.image_size);
								pct = PROG_XFER + PROG_W'(q);
								issue_chunk();
							end
						end else begin
							resend_chunk(OUT_FAILRETRY);
						end
					end
					PH_FINISH: end_run(ok);
					default: ;
				endcase
			end
			KIND_TIMEOUT: begin
				case (seq_phase)
					PH_REQ:    resend_request();
					PH_ERASE:  end_run(1'b0);
					PH_XFER:   resend_chunk(OUT_TIMERETRY);
					PH_FINISH: end_run(1'b0);
					default: ;
				endcase
			end
			KIND_CANCEL: begin
				if (seq_phase != PH_IDLE && seq_phase != PH_DONE && seq_phase != PH_FAIL) begin
					was_cancelled = 1'b1;
					end_run(1'b0);
				end
			end
			KIND_WAIT: begin
				if (!was_cancelled && seq_phase == PH_REQ) begin
					out_word.command = CMD_REQUEST;
				end
			end
			default: ;
		endcase
		out_word.phase = seq_phase;
		out_word.progress = pct;
		return out_word;
	endfunction

	// ------------------------------------------------------------------
	// Driver, receiver and monitor
	// ------------------------------------------------------------------

	// The event driver moves on at the falling edge after its word was taken,
	// or when nothing was offered. Gaps are rolled per cycle.
	always @(negedge clk) begin : event_driver
		seq_event_t nxt;
		if (!arst_n) begin
			ev_valid <= 1'b0;
		end else if (!ev_valid || event_accepted) begin
			if (pending_events.size() != 0 && !chance(send_gap_pct)) begin
				nxt = pending_events.pop_front();
				ev_valid <= 1'b1;
				ev_kind <= nxt.kind;
				ev_has <= nxt.has_status;
				ev_status <= nxt.status_byte;
			end else begin
				ev_valid <= 1'b0;
			end
		end
	end

	// The receiver stalls at random, and once for a long stretch on request.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			take_ready <= 1'b0;
		end else if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= HOLD_CYCLES;
			take_ready <= 1'b0;
		end else begin
			take_ready <= !chance(recv_gap_pct);
		end
	end

	// The monitor checks each result word against the oldest expectation.
	// A word arriving in the same cycle as a new event belongs to an older
	// event, so the check comes before the new prediction is queued.
	always @(posedge clk) begin : word_monitor
		result_t got;
		result_t want;
		event_accepted <= evt_ch.valid && evt_ch.ready;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				got.command = res_ch.command;
				got.chunk_offset = res_ch.chunk_offset;
				got.chunk_length = res_ch.chunk_length;
				got.phase = res_ch.phase;
				got.progress = res_ch.progress;
				got.packet_number = res_ch.packet_number;
				got.packet_outcome = res_ch.packet_outcome;
				got.finished = res_ch.finished;
				got.succeeded = res_ch.succeeded;
				if (expected_words.size() == 0) begin
					if (fail_count < 10) begin
						$display("word %0d arrived with none expected: %s", words_seen,
							show(got));
					end
					fail_count++;
				end else begin
					want = expected_words.pop_front();
					if (got.command !== want.command ||
							got.chunk_offset !== want.chunk_offset ||
							got.chunk_length !== want.chunk_length ||
							got.phase !== want.phase ||
							got.progress !== want.progress ||
							got.packet_number !== want.packet_number ||
							got.packet_outcome !== want.packet_outcome ||
							got.finished !== want.finished ||
							got.succeeded !== want.succeeded) begin
						if (fail_count < 10) begin
							$display("word %0d mismatch", words_seen);
							$display("  expected %s", show(want));
							$display("  actual   %s", show(got));
						end
						fail_count++;
					end
				end
				words_seen++;
			end
			if (evt_ch.valid && evt_ch.ready) begin
				expected_words.push_back(predict_event({evt_ch.kind, evt_ch.has_status,
					evt_ch.status_byte}));
				events_taken++;
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	task automatic queue_event(input logic [2:0] kind, input logic has, input logic [7:0] st);
		pending_events.push_back('{kind: kind, has_status: has, status_byte: st});
		events_queued++;
	endtask

	// One APB write: setup cycle, then access cycle until pready. The shadow
	// copy follows, since the block is idle whenever registers change.
	task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_IMAGE_SIZE:  cfg_now.image_size = value[SIZE_W-1:0];
			REG_MAX_RETRIES: cfg_now.max_retries = value[RETRY_W-1:0];
			REG_BOOT_READY:  cfg_now.boot_ready_code = value[CODE_W-1:0];
			REG_BOOT_STATUS: cfg_now.boot_status_code = value[CODE_W-1:0];
			REG_APP_JUMPING: cfg_now.app_jumping_code = value[CODE_W-1:0];
			REG_SUCCESS:     cfg_now.success_code = value[CODE_W-1:0];
			default: ;
		endcase
	endtask

	// Writes every register, then returns at a rising edge.
	task automatic program_regs(input logic [SIZE_W-1:0] size, input logic [7:0] retries,
			input logic [7:0] ready_code, input logic [7:0] status_code,
			input logic [7:0] jump_code, input logic [7:0] ok_code);
		write_reg(REG_IMAGE_SIZE, DATA_W'(size));
		write_reg(REG_MAX_RETRIES, DATA_W'(retries));
		write_reg(REG_BOOT_READY, DATA_W'(ready_code));
		write_reg(REG_BOOT_STATUS, DATA_W'(status_code));
		write_reg(REG_APP_JUMPING, DATA_W'(jump_code));
		write_reg(REG_SUCCESS, DATA_W'(ok_code));
		@(posedge clk);
	endtask

	// Waits until every queued event was taken and every word has come back.
	// The check runs at falling edges, where the counters are stable.
	task automatic wait_drained();
		do @(negedge clk);
		while (events_taken != events_queued || expected_words.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_status();
		case ($urandom_range(4, 0))
			0: return cfg_now.boot_ready_code;
			1: return cfg_now.boot_status_code;
			2: return cfg_now.app_jumping_code;
			3: return cfg_now.success_code;
			default: return 8'($urandom);
		endcase
	endfunction

	// A broken step: a timeout, a reply without status, or a reply whose
	// status differs from the success code in one bit.
	task automatic queue_fault();
		case ($urandom_range(2, 0))
			0: queue_event(KIND_TIMEOUT, 1'($urandom), 8'($urandom));
			1: queue_event(KIND_REPLY, 1'b0, 8'($urandom));
			default: queue_event(KIND_REPLY, 1'b1,
				cfg_now.success_code ^ (8'd1 << $urandom_range(7, 0)));
		endcase
	endtask

	// A mostly well-formed upgrade: start, a few request retries, the boot
	// reply, the erase, the data packets with occasional faults, the final
	// reply. Long images are cut off after max_pkts packets.
	task automatic add_session(input int unsigned max_pkts);
		int unsigned npk;
		queue_event(KIND_START, 1'($urandom), 8'($urandom));
		repeat ($urandom_range(2, 0)) begin
			case ($urandom_range(3, 0))
				0: queue_event(KIND_REPLY, 1'b0, 8'($urandom));
				1: begin
					queue_event(KIND_REPLY, 1'b1, cfg_now.app_jumping_code);
					queue_event(KIND_WAIT, 1'($urandom), 8'($urandom));
				end
				2: queue_event(KIND_TIMEOUT, 1'($urandom), 8'($urandom));
				default: queue_event(KIND_REPLY, 1'b1, pick_status());
			endcase
		end
		queue_event(KIND_REPLY, 1'b1,
			chance(50) ? cfg_now.boot_ready_code : cfg_now.boot_status_code);
		if (chance(8)) begin
			queue_fault();
		end else begin
			queue_event(KIND_REPLY, 1'b1, cfg_now.success_code);
		end
		npk = cfg_now.image_size / CHUNK_BYTES + 1;
		if (npk > max_pkts) begin
			npk = max_pkts;
		end
		repeat (npk) begin
			if (chance(12)) begin
				queue_fault();
			end
			queue_event(KIND_REPLY, 1'b1, cfg_now.success_code);
		end
		if (chance(6)) begin
			queue_event(KIND_CANCEL, 1'($urandom), 8'($urandom));
		end else if (chance(10)) begin
			queue_fault();
		end else begin
			queue_event(KIND_REPLY, 1'b1, cfg_now.success_code);
		end
	endtask

	// Random part of a phase: mostly upgrades, the rest bursts of noise with
	// any kind, the unused ones included.
	task automatic add_random(input int unsigned count, input int unsigned max_pkts);
		int unsigned target;
		target = events_queued + count;
		while (events_queued < target) begin
			if (chance(75)) begin
				add_session(max_pkts);
			end else begin
				repeat ($urandom_range(4, 1)) begin
					queue_event(3'($urandom_range(7, 0)), 1'($urandom), pick_status());
				end
			end
		end
	endtask

	initial begin
		// Reset once, then release it away from the rising edge.
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with the reset configuration: an empty image, the
		// request retries, the jumping code with its wait, both outcomes of
		// a data packet, the finish, unused kinds, the retry limit and cancel.
		queue_event(KIND_REPLY, 1'b1, cfg_now.boot_ready_code);
		queue_event(KIND_WAIT, 1'b0, 8'hFF);
		queue_event(KIND_START, 1'b0, 8'h00);
		queue_event(KIND_REPLY, 1'b0, 8'hFF);
		queue_event(KIND_REPLY, 1'b1, cfg_now.app_jumping_code);
		queue_event(KIND_WAIT, 1'b1, 8'h00);
		queue_event(KIND_TIMEOUT, 1'b0, 8'h00);
		queue_event(KIND_REPLY, 1'b1, cfg_now.boot_status_code);
		queue_event(KIND_REPLY, 1'b1, cfg_now.success_code);
		queue_event(KIND_TIMEOUT, 1'b1, 8'hFF);
		queue_event(KIND_REPLY, 1'b0, cfg_now.success_code);
		queue_event(KIND_REPLY, 1'b1, cfg_now.success_code);
		queue_event(KIND_REPLY, 1'b1, cfg_now.success_code);
		for (int k = 1; k <= 3; k++) begin
			queue_event(3'(KIND_WAIT + k), 1'b1, 8'hFF);
		end
		queue_event(KIND_START, 1'b1, 8'hFF);
		queue_event(KIND_REPLY, 1'b1, 8'hFF);
		queue_event(KIND_TIMEOUT, 1'b0, 8'h00);
		queue_event(KIND_REPLY, 1'b0, 8'h00);
		queue_event(KIND_START, 1'b0, 8'h00);
		queue_event(KIND_REPLY, 1'b1, cfg_now.boot_ready_code);
		queue_event(KIND_CANCEL, 1'b1, 8'hFF);
		queue_event(KIND_START, 1'b0, 8'h00);
		queue_event(KIND_REPLY, 1'b1, cfg_now.boot_ready_code);
		queue_event(KIND_TIMEOUT, 1'b0, 8'h00);
		wait_drained();

		// Sender idles in 9 percent of cycles, receiver in 80.
		program_regs(24'd1000, 8'd3, 8'h5A, 8'hA5, 8'h3C, 8'h00);
		add_random(300, 12);
		wait_drained();

		// One-byte image, a retry limit of one (the first retry already fails), and all codes
		// equal, so the boot codes must take precedence over the jumping code.
		program_regs(24'd1, 8'd1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		add_random(150, 4);
		wait_drained();

		// Now the sender idles in 80 percent of cycles, the receiver in 9.
		send_gap_pct = 80;
		recv_gap_pct = 9;
		program_regs(24'd300, 8'd255, 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom));
		add_random(300, 6);
		wait_drained();

		// Largest image and a retry limit of zero: every retry fails. The phase
		// ends in the middle of a transfer, five packets in.
		program_regs(24'hFFFFFF, 8'd0, 8'd0, 8'd1, 8'd2, 8'd0);
		add_random(150, 8);
		queue_event(KIND_START, 1'b0, 8'h00);
		queue_event(KIND_REPLY, 1'b1, cfg_now.boot_ready_code);
		repeat (6) queue_event(KIND_REPLY, 1'b1, cfg_now.success_code);
		wait_drained();

		// Neither side idles from here on. The image shrinks below the current
		// offset, so the resent chunk is empty and the next success ends the
		// transfer. The receiver then holds off for a long stretch while the
		// sender keeps offering.
		send_gap_pct = 0;
		recv_gap_pct = 0;
		program_regs(24'd50, 8'd255, 8'h10, 8'h11, 8'h12, 8'h00);
		queue_event(KIND_REPLY, 1'b1, 8'h77);
		queue_event(KIND_REPLY, 1'b1, cfg_now.success_code);
		add_random(300, 4);
		hold_req = !hold_req;
		wait_drained();

		// Longer images with random codes and limits.
		program_regs(24'($urandom_range(4000, 0)), 8'($urandom_range(8, 1)), 8'($urandom),
			8'($urandom), 8'($urandom), 8'($urandom));
		add_random(550, 40);
		wait_drained();

		repeat (20) @(posedge clk);
		if (fail_count == 0 && expected_words.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
